// ----- src/rpec_pkg.sv -----
package rpec_pkg;

  // Fixed field widths of the item format
  localparam int IDX_W    = 16;
  localparam int DIR_W    = 18;
  localparam int FRAC_W   = 16;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  // Defaults for the top-level parameters
  localparam int NUM_PARTICLES_DEF = 65536;
  localparam int VEL_WIDTH_DEF     = 20;

  // Command codes carried in in_tuser
  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COLLIDE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

  // Status codes carried in out_tuser
  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DATA,
    ST_SUM,
    ST_SCALE,
    ST_UPD,
    ST_WR_B,
    ST_RESP
  } st_t;

endpackage

// ----- src/random_pair_elastic_collision.sv -----
// Particle velocity store with binary elastic collisions. Each input item is a
// command in in_tuser: write a particle's three velocity components, read them
// back, or collide particles A and B along the supplied unit direction d. A
// collide computes tau = d . (vA - vB) (floored to 16 fraction bits), then
// stores vA - d*tau for A and vB + d*tau for B, each product floored and each
// component saturated to the signed velocity range; the result item carries
// the new velocity of A. Every item yields exactly one result item with a
// status in out_tuser: ok, rejected (index out of range, or equal indices on
// a collide; store untouched, velocities zero) or saturated (both particles
// still written). Unused command code 3 returns all zeros. Items are handled
// one at a time: a write, a rejected item or the unused code goes from
// execute straight to the response state, a read passes the data state,
// and a collide the data, sum, scale, update and write-B states. The next
// item is taken once the result is in the output register, whose loading
// waits while it is full. The collide path is set by the single-write-port
// store (A and B are written in separate cycles), the registered read and
// the two dependent multiply stages (products for tau, then d*tau). The
// store itself has no reset: an entry reads back undefined until written.
module random_pair_elastic_collision #(
  parameter int NUM_PARTICLES = rpec_pkg::NUM_PARTICLES_DEF,
  parameter int VEL_WIDTH     = rpec_pkg::VEL_WIDTH_DEF,
  localparam int IN_BITS      = 2 * rpec_pkg::IDX_W + 3 * rpec_pkg::DIR_W + 3 * VEL_WIDTH,
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA_W  = ((3 * VEL_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata, from bit 0 up: index_a, index_b, dir_x, dir_y, dir_z,
  // vel_in_x, vel_in_y, vel_in_z, zero padding
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [IN_TDATA_W-1:0]            in_tdata,
  input  logic [rpec_pkg::CMD_W-1:0]       in_tuser,    // command
  // out_tdata, from bit 0 up: vel_out_x, vel_out_y, vel_out_z, zero padding
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [OUT_TDATA_W-1:0]           out_tdata,
  output logic [rpec_pkg::STATUS_W-1:0]    out_tuser    // status
);

  localparam int VW      = VEL_WIDTH;
  localparam int VEC_W   = 3 * VW;
  localparam int AW      = $clog2(NUM_PARTICLES);
  localparam int IW      = rpec_pkg::IDX_W;
  localparam int DW      = rpec_pkg::DIR_W;
  localparam int FW      = rpec_pkg::FRAC_W;
  localparam int DIFF_W  = VW + 1;           // vA - vB
  localparam int PROD_W  = DIFF_W + DW;      // d * (vA - vB), 32 fraction bits
  localparam int SUM_W   = PROD_W + 2;       // sum of three products
  localparam int TAU_W   = SUM_W - FW;       // tau, 16 fraction bits
  localparam int DPROD_W = TAU_W + DW;       // d * tau, 32 fraction bits
  localparam int DELTA_W = DPROD_W - FW;     // delta, 16 fraction bits
  localparam int NEW_W   = DELTA_W + 1;      // vA - delta, vB + delta
  localparam int VB_BASE = 2 * IW + 3 * DW;  // first velocity bit in in_tdata

  localparam logic signed [NEW_W-1:0] VMAX = {{(NEW_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [NEW_W-1:0] VMIN = {{(NEW_W-VW+1){1'b1}}, {(VW-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // Item registers, loaded at acceptance
  // ---------------------------------------------------------------------------
  rpec_pkg::st_t state_r, state_nxt;

  logic [rpec_pkg::CMD_W-1:0] cmd_r;
  logic [IW-1:0]              idx_a_r, idx_b_r;
  logic signed [DW-1:0]       dir_r [3];
  logic [VEC_W-1:0]           vin_r;

  logic in_accept;
  assign in_accept = in_tvalid && in_tready;

  // Range checks and memory addresses from the held indices
  logic [31:0] ia_ext, ib_ext;
  logic        a_ok, b_ok, pair_ok;
  logic [AW-1:0] addr_a, addr_b;

  assign ia_ext  = {{(32-IW){1'b0}}, idx_a_r};
  assign ib_ext  = {{(32-IW){1'b0}}, idx_b_r};
  assign a_ok    = ia_ext < 32'(NUM_PARTICLES);
  assign b_ok    = ib_ext < 32'(NUM_PARTICLES);
  assign pair_ok = a_ok && b_ok && (idx_a_r != idx_b_r);
  assign addr_a  = ia_ext[AW-1:0];
  assign addr_b  = ib_ext[AW-1:0];

  // ---------------------------------------------------------------------------
  // Velocity store: one write port, two registered read ports
  // ---------------------------------------------------------------------------
  logic [VEC_W-1:0] vel_mem [NUM_PARTICLES];
  logic [VEC_W-1:0] rd_a_r, rd_b_r;
  logic             mem_we, rd_en;
  logic [AW-1:0]    mem_waddr;
  logic [VEC_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vel_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_a_r <= vel_mem[addr_a];
      rd_b_r <= vel_mem[addr_b];
    end
  end

  // ---------------------------------------------------------------------------
  // Collision datapath
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0]  prod_r  [3];
  logic signed [TAU_W-1:0]   tau_r;
  logic signed [DELTA_W-1:0] delta_r [3];
  logic [VEC_W-1:0]          nb_r;

  logic signed [VW-1:0]      va [3], vb [3];
  logic signed [DIFF_W-1:0]  diff [3];
  logic signed [PROD_W-1:0]  prod [3];
  logic signed [SUM_W-1:0]   sum;
  logic signed [DPROD_W-1:0] dprod [3];
  logic signed [NEW_W-1:0]   na_w [3], nb_w [3];
  logic [VEC_W-1:0]          na_vec, nb_vec;
  logic [2:0]                ovf;

  function automatic logic [VW-1:0] clip(input logic signed [NEW_W-1:0] x);
    logic [VW-1:0] r;
    if (x > VMAX) begin
      r = VMAX[VW-1:0];
    end else if (x < VMIN) begin
      r = VMIN[VW-1:0];
    end else begin
      r = x[VW-1:0];
    end
    return r;
  endfunction

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      va[k]   = rd_a_r[k*VW +: VW];
      vb[k]   = rd_b_r[k*VW +: VW];
      diff[k] = {va[k][VW-1], va[k]} - {vb[k][VW-1], vb[k]};
      // operands extended to the product width, so the product is exact
      prod[k] = {{(PROD_W-DW){dir_r[k][DW-1]}}, dir_r[k]}
              * {{(PROD_W-DIFF_W){diff[k][DIFF_W-1]}}, diff[k]};
      dprod[k] = {{(DPROD_W-DW){dir_r[k][DW-1]}}, dir_r[k]}
               * {{(DPROD_W-TAU_W){tau_r[TAU_W-1]}}, tau_r};
      na_w[k] = {{(NEW_W-VW){va[k][VW-1]}}, va[k]}
              - {delta_r[k][DELTA_W-1], delta_r[k]};
      nb_w[k] = {{(NEW_W-VW){vb[k][VW-1]}}, vb[k]}
              + {delta_r[k][DELTA_W-1], delta_r[k]};
      ovf[k]  = (na_w[k] > VMAX) || (na_w[k] < VMIN)
             || (nb_w[k] > VMAX) || (nb_w[k] < VMIN);
      na_vec[k*VW +: VW] = clip(na_w[k]);
      nb_vec[k*VW +: VW] = clip(nb_w[k]);
    end
    sum = {{(SUM_W-PROD_W){prod_r[0][PROD_W-1]}}, prod_r[0]}
        + {{(SUM_W-PROD_W){prod_r[1][PROD_W-1]}}, prod_r[1]}
        + {{(SUM_W-PROD_W){prod_r[2][PROD_W-1]}}, prod_r[2]};
  end

  // ---------------------------------------------------------------------------
  // Result holding and output register
  // ---------------------------------------------------------------------------
  logic [VEC_W-1:0]              res_vel_r;
  logic [rpec_pkg::STATUS_W-1:0] res_status_r;
  logic                          out_tvalid_r;
  logic [OUT_TDATA_W-1:0]        out_tdata_r;
  logic [rpec_pkg::STATUS_W-1:0] out_tuser_r;
  logic                          out_free, out_load;

  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rpec_pkg::ST_IDLE: begin
        if (in_accept) state_nxt = rpec_pkg::ST_EXEC;
      end
      rpec_pkg::ST_EXEC: begin
        // a good read or collide waits on the store; anything else answers now
        if ((cmd_r == rpec_pkg::CMD_READ && a_ok) ||
            (cmd_r == rpec_pkg::CMD_COLLIDE && pair_ok)) begin
          state_nxt = rpec_pkg::ST_DATA;
        end else begin
          state_nxt = rpec_pkg::ST_RESP;
        end
      end
      rpec_pkg::ST_DATA: begin
        state_nxt = (cmd_r == rpec_pkg::CMD_COLLIDE) ? rpec_pkg::ST_SUM : rpec_pkg::ST_RESP;
      end
      rpec_pkg::ST_SUM:   state_nxt = rpec_pkg::ST_SCALE;
      rpec_pkg::ST_SCALE: state_nxt = rpec_pkg::ST_UPD;
      rpec_pkg::ST_UPD:   state_nxt = rpec_pkg::ST_WR_B;
      rpec_pkg::ST_WR_B:  state_nxt = rpec_pkg::ST_RESP;
      rpec_pkg::ST_RESP: begin
        if (out_free) state_nxt = rpec_pkg::ST_IDLE;
      end
      default: state_nxt = rpec_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = addr_a;
    mem_wdata = vin_r;
    rd_en     = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      rpec_pkg::ST_IDLE: in_tready = 1'b1;
      rpec_pkg::ST_EXEC: begin
        mem_we = (cmd_r == rpec_pkg::CMD_WRITE) && a_ok;
        rd_en  = 1'b1;
      end
      rpec_pkg::ST_UPD: begin
        // write A now, B in the next cycle through the same port
        mem_we    = 1'b1;
        mem_wdata = na_vec;
      end
      rpec_pkg::ST_WR_B: begin
        mem_we    = 1'b1;
        mem_waddr = addr_b;
        mem_wdata = nb_r;
      end
      rpec_pkg::ST_RESP: out_load = out_free;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rpec_pkg::ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r    <= in_tuser;
      idx_a_r  <= in_tdata[IW-1:0];
      idx_b_r  <= in_tdata[2*IW-1:IW];
      dir_r[0] <= in_tdata[2*IW +: DW];
      dir_r[1] <= in_tdata[2*IW+DW +: DW];
      dir_r[2] <= in_tdata[2*IW+2*DW +: DW];
      vin_r    <= in_tdata[VB_BASE +: VEC_W];
    end

    unique case (state_r)
      rpec_pkg::ST_EXEC: begin
        // zero velocities for write, reject and the unused code
        res_vel_r <= '0;
        if (cmd_r == rpec_pkg::CMD_WRITE || cmd_r == rpec_pkg::CMD_READ) begin
          res_status_r <= a_ok ? rpec_pkg::STATUS_OK : rpec_pkg::STATUS_REJECT;
        end else if (cmd_r == rpec_pkg::CMD_COLLIDE) begin
          res_status_r <= pair_ok ? rpec_pkg::STATUS_OK : rpec_pkg::STATUS_REJECT;
        end else begin
          res_status_r <= rpec_pkg::STATUS_OK;
        end
      end
      rpec_pkg::ST_DATA: begin
        res_vel_r <= rd_a_r;
        for (int k = 0; k < 3; k++) begin
          prod_r[k] <= prod[k];
        end
      end
      rpec_pkg::ST_SUM: begin
        // floor by dropping the low fraction bits
        tau_r <= sum[SUM_W-1:FW];
      end
      rpec_pkg::ST_SCALE: begin
        for (int k = 0; k < 3; k++) begin
          delta_r[k] <= dprod[k][DPROD_W-1:FW];
        end
      end
      rpec_pkg::ST_UPD: begin
        nb_r         <= nb_vec;
        res_vel_r    <= na_vec;
        res_status_r <= (|ovf) ? rpec_pkg::STATUS_SAT : rpec_pkg::STATUS_OK;
      end
      default: ;
    endcase

    if (out_load) begin
      out_tdata_r <= {{(OUT_TDATA_W-VEC_W){1'b0}}, res_vel_r};
      out_tuser_r <= res_status_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == rpec_pkg::ST_EXEC)
    else $error("accepted item did not start execution");

  a_pair_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rpec_pkg::ST_WR_B |-> (idx_a_r != idx_b_r) && a_ok && b_ok)
    else $error("collision write-back for a rejected pair");

  a_exec_write_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rpec_pkg::ST_EXEC && mem_we) |-> cmd_r == rpec_pkg::CMD_WRITE)
    else $error("store written by a non-write command at execute");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tuser_r == rpec_pkg::STATUS_REJECT) |-> out_tdata_r == '0)
    else $error("rejected item carries nonzero velocity");

  a_upd_then_b: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rpec_pkg::ST_UPD |=> state_r == rpec_pkg::ST_WR_B && mem_we)
    else $error("particle B not written after particle A");

endmodule
